[hdl/textured_column_renderer_defines.svh]
// Assertion macros shared by the textured column renderer modules.
`ifndef TEXTURED_COLUMN_RENDERER_DEFINES_SVH
`define TEXTURED_COLUMN_RENDERER_DEFINES_SVH

`ifndef ASSERT_OFF

// Check prop at every rising edge of clk while rstn is high.
`define TCR_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("textured column renderer assertion failed");

// Check prop at every rising edge of clk, reset included.
`define TCR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("textured column renderer assertion failed");

`else

`define TCR_ASSERT(label, clk, rstn, prop)
`define TCR_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[hdl/tcr_pkg.sv]
// Shared widths, codes and handshake structs of the textured column renderer.
`default_nettype none

package tcr_pkg;

    localparam int COLOR_W   = 24;
    localparam int COORD_W   = 12;
    localparam int HEIGHT_W  = 16;
    localparam int TEXCOL_W  = 6;
    localparam int SEL_W     = 2;
    localparam int TEXIDX_W  = 12;
    localparam int PIXADDR_W = 24;
    localparam int STEP_W    = 32;
    localparam int POS_W     = 48;
    localparam int FRAC_W    = 16;
    localparam int OFS_W     = 17;
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 48;

    // Item kinds carried in s_tuser
    localparam logic [FUNC_W-1:0] FUNC_COLUMN = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ROW    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TEXEL  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd3;

    localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH  = 12'd640;
    localparam logic [COORD_W-1:0] RST_SCREEN_HEIGHT = 12'd480;

    typedef struct packed {
        logic                start;
        logic [HEIGHT_W-1:0] divisor;
        logic [OFS_W-1:0]    offset;   // two's complement
    } tcr_setup_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [STEP_W-1:0] step;
        logic [POS_W-1:0]  pos;
    } tcr_setup_rsp_t;

endpackage

`default_nettype wire

[hdl/tcr_tex_mem.sv]
// Texture store: single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tcr_tex_mem #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/tcr_col_setup.sv]
// Column setup: bit-serial texture step divider followed by the start-position multiply.
`default_nettype none
`include "textured_column_renderer_defines.svh"

module tcr_col_setup import tcr_pkg::*; #(
    parameter int TEX_SIZE = 64
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire tcr_setup_req_t req,
    output tcr_setup_rsp_t      rsp
);

    localparam int TEX_BITS = $clog2(TEX_SIZE);
    localparam int DIV_W    = TEX_BITS + FRAC_W + 1;
    localparam int CNT_W    = $clog2(DIV_W + 1);
    localparam int PROD_W   = OFS_W + DIV_W + 1;

    localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(TEX_SIZE) << FRAC_W;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIV_W - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [HEIGHT_W-1:0] div_reg, div_next;
    logic [HEIGHT_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]    qd_reg, qd_next;
    logic [OFS_W-1:0]    ofs_reg, ofs_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [POS_W-1:0]    pos_reg, pos_next;

    logic [HEIGHT_W:0]        rem_sh;
    logic [HEIGHT_W:0]        rem_diff;
    logic                     rem_ge;
    logic signed [PROD_W-1:0] prod;
    logic                     div_last;

    // Restoring division: shift one dividend bit in per cycle
    assign rem_sh   = {rem_reg, qd_reg[DIV_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, div_reg};
    assign rem_diff = rem_sh - {1'b0, div_reg};

    assign prod = $signed(ofs_reg) * $signed({1'b0, qd_reg});

    assign div_last = (state_reg == ST_DIV) && (cnt_reg == LAST_CNT);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        qd_next    = qd_reg;
        ofs_next   = ofs_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        pos_next   = pos_reg;
        case (state_reg)
            ST_IDLE: begin
                if (req.start) begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                    div_next   = req.divisor;
                    rem_next   = '0;
                    qd_next    = DIVIDEND;
                    ofs_next   = req.offset;
                end
            end
            ST_DIV: begin
                rem_next = rem_ge ? rem_diff[HEIGHT_W-1:0] : rem_sh[HEIGHT_W-1:0];
                qd_next  = {qd_reg[DIV_W-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                step_next  = STEP_W'(qd_reg);
                pos_next   = {{(POS_W - PROD_W){prod[PROD_W-1]}}, prod};
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        qd_reg   <= qd_next;
        ofs_reg  <= ofs_next;
        step_reg <= step_next;
        pos_reg  <= pos_next;
    end

    assign rsp.busy = (state_reg != ST_IDLE) || done_reg;
    assign rsp.done = done_reg;
    assign rsp.step = step_reg;
    assign rsp.pos  = pos_reg;

    `TCR_ASSERT(a_start_goes_busy, aclk, aresetn, req.start |=> rsp.busy)
    `TCR_ASSERT(a_done_single_pulse, aclk, aresetn, done_reg |=> !done_reg)
    `TCR_ASSERT(a_div_ends_in_mul, aclk, aresetn, div_last |=> (state_reg == ST_MUL))

endmodule

`default_nettype wire

[hdl/textured_column_renderer.sv]
// Top level: column state, row pipeline, texture store and configuration registers.
//
//  channel   direction  payload                                   handshake
//  s_        in         tuser: func; tdata: column start / texel  tvalid/tready
//  m_        out        tdata: address, color; tlast: last row    tvalid/tready
//  cfg_      in         cfg_index, cfg_wr_data                    cfg_wr_en
//
// A pixel reaches m_ through the read stage (texture read), then the output register;
// ticks stream at one per clock while the setup is idle and m_ is not stalled.
// A column start holds s_tready low while the divider runs, then through the multiply
// and the load of its result.
// Reset (aresetn low at a clock edge) clears control state; the texture store keeps
// its contents and needs no clearing pass.
// A stalled m_ side holds one pixel in the output register and one in the read stage,
// then drops s_tready.
`default_nettype none
`include "textured_column_renderer_defines.svh"

module textured_column_renderer import tcr_pkg::*; #(
    parameter int TEX_SIZE     = 64,
    parameter int NUM_TEXTURES = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // lowest bit up: column, span_start, span_end, wall_height, texture_column,
    // texture_select, texel_index, texel_value
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // func
    input  wire logic [FUNC_W-1:0]    s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // lowest bit up: pixel_address, pixel_color
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic                      m_tlast,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_wr_data
);

    localparam int TEX_BITS = $clog2(TEX_SIZE);
    localparam int AREA_W   = 2 * TEX_BITS;
    localparam int FULL_W   = 4 + AREA_W;
    localparam int DEPTH    = NUM_TEXTURES << AREA_W;
    localparam int ADDR_W   = $clog2(DEPTH);

    // Input fields
    logic [FUNC_W-1:0]   in_func;
    logic [COORD_W-1:0]  in_column;
    logic [COORD_W-1:0]  in_span_start;
    logic [COORD_W-1:0]  in_span_end;
    logic [HEIGHT_W-1:0] in_height;
    logic [TEXCOL_W-1:0] in_tex_col;
    logic [SEL_W-1:0]    in_sel;
    logic [TEXIDX_W-1:0] in_texel_index;
    logic [COLOR_W-1:0]  in_texel_value;

    assign in_func        = s_tuser;
    assign in_column      = s_tdata[11:0];
    assign in_span_start  = s_tdata[23:12];
    assign in_span_end    = s_tdata[35:24];
    assign in_height      = s_tdata[51:36];
    assign in_tex_col     = s_tdata[57:52];
    assign in_sel         = s_tdata[59:58];
    assign in_texel_index = s_tdata[71:60];
    assign in_texel_value = s_tdata[95:72];

    // Configuration
    logic [COLOR_W-1:0] ceil_color_reg, ceil_color_next;
    logic [COLOR_W-1:0] floor_color_reg, floor_color_next;
    logic [COORD_W-1:0] sw_reg, sw_next;
    logic [COORD_W-1:0] sh_reg, sh_next;

    // Column state
    logic [COORD_W-1:0]  row_counter_reg, row_counter_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [COORD_W-1:0]  col_reg, col_next;
    logic [COORD_W-1:0]  span_start_reg, span_start_next;
    logic [COORD_W-1:0]  span_end_reg, span_end_next;
    logic [TEXCOL_W-1:0] tex_col_reg, tex_col_next;
    logic [SEL_W-1:0]    sel_reg, sel_next;

    // Read stage and output register
    logic                 s2_valid_reg, s2_valid_next;
    logic [PIXADDR_W-1:0] s2_addr_reg, s2_addr_next;
    logic [COLOR_W-1:0]   s2_color_reg, s2_color_next;
    logic                 s2_use_tex_reg, s2_use_tex_next;
    logic                 s2_last_reg, s2_last_next;
    logic                 m_valid_reg, m_valid_next;
    logic [PIXADDR_W-1:0] m_addr_reg, m_addr_next;
    logic [COLOR_W-1:0]   m_color_reg, m_color_next;
    logic                 m_last_reg, m_last_next;

    logic accept, is_col, is_row, is_texel, out_free;
    logic in_sel_ok, lat_sel_ok;
    logic tick_live, above_span, in_span;
    logic [PIXADDR_W-1:0] row_base, pix_addr;
    logic                 row_last;

    logic [FULL_W-1:0]  wr_full, rd_full;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic               wr_en, rd_en;
    logic [COLOR_W-1:0] rd_data;

    tcr_setup_req_t setup_req;
    tcr_setup_rsp_t setup_rsp;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !setup_rsp.busy && (!s2_valid_reg || out_free);
    assign accept   = s_tvalid && s_tready;
    assign is_col   = accept && (in_func == FUNC_COLUMN);
    assign is_row   = accept && (in_func == FUNC_ROW);
    assign is_texel = accept && (in_func == FUNC_TEXEL);

    assign in_sel_ok  = 5'(in_sel) < 5'(NUM_TEXTURES);
    assign lat_sel_ok = 5'(sel_reg) < 5'(NUM_TEXTURES);

    // Texture store ports
    assign wr_full = {4'(in_sel), AREA_W'(in_texel_index)};
    assign wr_addr = wr_full[ADDR_W-1:0];
    assign wr_en   = is_texel && in_sel_ok;

    assign rd_full = {4'(sel_reg), pos_reg[FRAC_W +: TEX_BITS], TEX_BITS'(tex_col_reg)};
    assign rd_addr = rd_full[ADDR_W-1:0];

    // Row classification
    assign tick_live  = row_counter_reg < sh_reg;
    assign above_span = row_counter_reg < span_start_reg;
    assign in_span    = !above_span && (row_counter_reg < span_end_reg);
    assign rd_en      = is_row && tick_live && in_span && lat_sel_ok;

    assign row_base = {{(PIXADDR_W - COORD_W){1'b0}}, sw_reg}
                    * {{(PIXADDR_W - COORD_W){1'b0}}, row_counter_reg};
    assign pix_addr = row_base + {{(PIXADDR_W - COORD_W){1'b0}}, col_reg};
    assign row_last = ({1'b0, row_counter_reg} + 13'd1) == {1'b0, sh_reg};

    // Column setup request
    assign setup_req.start   = is_col;
    assign setup_req.divisor = (in_height == '0) ? 16'd1 : in_height;
    assign setup_req.offset  = {5'b0, in_span_start} - {6'b0, sh_reg[COORD_W-1:1]}
                             + {2'b0, in_height[HEIGHT_W-1:1]};

    tcr_col_setup #(
        .TEX_SIZE (TEX_SIZE)
    ) u_setup (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (setup_req),
        .rsp     (setup_rsp)
    );

    tcr_tex_mem #(
        .DATA_W (COLOR_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_tex_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_texel_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        ceil_color_next  = ceil_color_reg;
        floor_color_next = floor_color_reg;
        sw_next          = sw_reg;
        sh_next          = sh_reg;
        row_counter_next = row_counter_reg;
        pos_next         = pos_reg;
        step_next        = step_reg;
        col_next         = col_reg;
        span_start_next  = span_start_reg;
        span_end_next    = span_end_reg;
        tex_col_next     = tex_col_reg;
        sel_next         = sel_reg;
        s2_valid_next    = s2_valid_reg;
        s2_addr_next     = s2_addr_reg;
        s2_color_next    = s2_color_reg;
        s2_use_tex_next  = s2_use_tex_reg;
        s2_last_next     = s2_last_reg;
        m_valid_next     = m_valid_reg;
        m_addr_next      = m_addr_reg;
        m_color_next     = m_color_reg;
        m_last_next      = m_last_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CEILING: ceil_color_next  = cfg_wr_data;
                CFG_FLOOR:   floor_color_next = cfg_wr_data;
                CFG_WIDTH:   sw_next          = cfg_wr_data[COORD_W-1:0];
                CFG_HEIGHT:  sh_next          = cfg_wr_data[COORD_W-1:0];
                default: begin
                end
            endcase
        end

        if (is_col) begin
            col_next        = in_column;
            span_start_next = in_span_start;
            span_end_next   = in_span_end;
            tex_col_next    = in_tex_col;
            sel_next        = in_sel;
        end

        if (setup_rsp.done) begin
            step_next        = setup_rsp.step;
            pos_next         = setup_rsp.pos;
            row_counter_next = '0;
        end

        // Drain the read stage into the output register
        if (out_free) begin
            m_valid_next  = s2_valid_reg;
            s2_valid_next = 1'b0;
            if (s2_valid_reg) begin
                m_addr_next  = s2_addr_reg;
                m_color_next = s2_use_tex_reg ? rd_data : s2_color_reg;
                m_last_next  = s2_last_reg;
            end
        end

        // Ticks after the last row are taken and dropped
        if (is_row && tick_live) begin
            row_counter_next = row_counter_reg + 1'b1;
            if (in_span) begin
                pos_next = pos_reg + {{(POS_W - STEP_W){1'b0}}, step_reg};
            end
            s2_valid_next   = 1'b1;
            s2_addr_next    = pix_addr;
            s2_use_tex_next = in_span && lat_sel_ok;
            s2_last_next    = row_last;
            s2_color_next   = above_span ? ceil_color_reg :
                              (in_span ? '0 : floor_color_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceil_color_reg  <= '0;
            floor_color_reg <= '0;
            sw_reg          <= RST_SCREEN_WIDTH;
            sh_reg          <= RST_SCREEN_HEIGHT;
            row_counter_reg <= RST_SCREEN_HEIGHT;
            pos_reg         <= '0;
            step_reg        <= '0;
            col_reg         <= '0;
            span_start_reg  <= '0;
            span_end_reg    <= '0;
            tex_col_reg     <= '0;
            sel_reg         <= '0;
            s2_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            ceil_color_reg  <= ceil_color_next;
            floor_color_reg <= floor_color_next;
            sw_reg          <= sw_next;
            sh_reg          <= sh_next;
            row_counter_reg <= row_counter_next;
            pos_reg         <= pos_next;
            step_reg        <= step_next;
            col_reg         <= col_next;
            span_start_reg  <= span_start_next;
            span_end_reg    <= span_end_next;
            tex_col_reg     <= tex_col_next;
            sel_reg         <= sel_next;
            s2_valid_reg    <= s2_valid_next;
            m_valid_reg     <= m_valid_next;
        end
        s2_addr_reg    <= s2_addr_next;
        s2_color_reg   <= s2_color_next;
        s2_use_tex_reg <= s2_use_tex_next;
        s2_last_reg    <= s2_last_next;
        m_addr_reg     <= m_addr_next;
        m_color_reg    <= m_color_next;
        m_last_reg     <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_color_reg, m_addr_reg};
    assign m_tlast  = m_last_reg;

    `TCR_ASSERT(a_hold_when_blocked, aclk, aresetn, (s2_valid_reg && !out_free) |-> !s_tready)
    `TCR_ASSERT(a_read_fills_stage, aclk, aresetn, rd_en |=> (s2_valid_reg && s2_use_tex_reg))
    `TCR_ASSERT(a_setup_restarts_rows, aclk, aresetn, setup_rsp.done |=> (row_counter_reg == 12'd0))
    `TCR_ASSERT_ALWAYS(a_no_result_after_reset, aclk, !aresetn |=> !m_tvalid)

endmodule

`default_nettype wire

[tb/tcr_pixel_checker.sv]
// Pixel checker for the textured column renderer: predicts every pixel and compares it.
`timescale 1ns / 1ps

module tcr_pixel_checker import tcr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [FUNC_W-1:0]    s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_wr_data,
    output int                   fail_count,
    output int                   pending_pixels
);

    localparam int TEX_DIM  = 64;
    localparam int TEX_BITS = 6;
    localparam int NUM_TEX  = 4;

    // s_tdata field offsets, lowest bit up
    localparam int SD_COLUMN = 0;
    localparam int SD_START  = 12;
    localparam int SD_END    = 24;
    localparam int SD_HEIGHT = 36;
    localparam int SD_TEXCOL = 52;
    localparam int SD_SEL    = 58;
    localparam int SD_TEXIDX = 60;
    localparam int SD_TEXVAL = 72;

    typedef struct packed {
        logic [PIXADDR_W-1:0] addr;
        logic [COLOR_W-1:0]   color;
        logic                 last;
    } pixel_t;

    pixel_t expected_pixels[$];

    logic [COLOR_W-1:0]  texels [0:NUM_TEX*TEX_DIM*TEX_DIM-1];

    logic [COLOR_W-1:0]  ceiling_rgb, floor_rgb;
    logic [COORD_W-1:0]  scr_width, scr_height;

    logic [COORD_W-1:0]  row;
    logic [POS_W-1:0]    tex_pos;
    logic [STEP_W-1:0]   tex_step;
    logic [COORD_W-1:0]  col_x, span_lo, span_hi;
    logic [TEXCOL_W-1:0] tex_x;
    logic [SEL_W-1:0]    tex_sel;

    task automatic report_failure(input string msg);
        $display("%0t ns: pixel check: %s", $time, msg);
        fail_count++;
    endtask

    task automatic start_column(input logic [S_TDATA_W-1:0] d);
        logic [HEIGHT_W-1:0] h;
        longint              offs;
        h = d[SD_HEIGHT +: HEIGHT_W];
        if (h == '0) begin
            h = 1;
        end
        col_x    = d[SD_COLUMN +: COORD_W];
        span_lo  = d[SD_START +: COORD_W];
        span_hi  = d[SD_END +: COORD_W];
        tex_x    = d[SD_TEXCOL +: TEXCOL_W];
        tex_sel  = d[SD_SEL +: SEL_W];
        tex_step = STEP_W'((64'(TEX_DIM) << FRAC_W) / 64'(h));
        // signed start offset of the span inside the wall, wrapped to 48 bits
        offs     = longint'(span_lo) - longint'(scr_height / 2) + longint'(h / 2);
        tex_pos  = POS_W'(offs * longint'({32'd0, tex_step}));
        row      = '0;
    endtask

    task automatic shade_row();
        logic [COLOR_W-1:0] rgb;
        logic [31:0]        lin;
        pixel_t             px;
        if (row < scr_height) begin
            if (row < span_lo) begin
                rgb = ceiling_rgb;
            end else if (row < span_hi) begin
                rgb = texels[{tex_sel, tex_pos[FRAC_W +: TEX_BITS], tex_x}];
                tex_pos = tex_pos + POS_W'(tex_step);
            end else begin
                rgb = floor_rgb;
            end
            lin = 32'(scr_width) * 32'(row) + 32'(col_x);
            px.addr  = lin[PIXADDR_W-1:0];
            px.color = rgb;
            px.last  = (32'(row) + 1 == 32'(scr_height));
            expected_pixels.push_back(px);
            row = row + 1'b1;
        end
    endtask

    always @(posedge aclk) begin : monitor
        pixel_t got, want;
        if (!aresetn) begin
            expected_pixels.delete();
            ceiling_rgb = '0;
            floor_rgb   = '0;
            scr_width   = RST_SCREEN_WIDTH;
            scr_height  = RST_SCREEN_HEIGHT;
            row         = RST_SCREEN_HEIGHT;
            tex_pos     = '0;
            tex_step    = '0;
            col_x       = '0;
            span_lo     = '0;
            span_hi     = '0;
            tex_x       = '0;
            tex_sel     = '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_CEILING: ceiling_rgb = cfg_wr_data;
                    CFG_FLOOR:   floor_rgb   = cfg_wr_data;
                    CFG_WIDTH:   scr_width   = cfg_wr_data[COORD_W-1:0];
                    CFG_HEIGHT:  scr_height  = cfg_wr_data[COORD_W-1:0];
                    default: ;
                endcase
            end
            // compare before predicting: a tick never yields its pixel on the same edge
            if (m_tvalid && m_tready) begin
                got.addr  = m_tdata[0 +: PIXADDR_W];
                got.color = m_tdata[PIXADDR_W +: COLOR_W];
                got.last  = m_tlast;
                if (expected_pixels.size() == 0) begin
                    report_failure($sformatf("pixel addr %h color %h last %b with none expected",
                                             got.addr, got.color, got.last));
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.addr !== want.addr)
                        report_failure($sformatf("pixel_address %h, expected %h",
                                                 got.addr, want.addr));
                    if (got.color !== want.color)
                        report_failure($sformatf("pixel_color %h at %h, expected %h",
                                                 got.color, want.addr, want.color));
                    if (got.last !== want.last)
                        report_failure($sformatf("last_row %b at %h, expected %b",
                                                 got.last, want.addr, want.last));
                end
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    FUNC_COLUMN: start_column(s_tdata);
                    FUNC_ROW:    shade_row();
                    FUNC_TEXEL:  texels[{s_tdata[SD_SEL +: SEL_W], s_tdata[SD_TEXIDX +: TEXIDX_W]}]
                                     = s_tdata[SD_TEXVAL +: COLOR_W];
                    default: ;
                endcase
            end
        end
        pending_pixels = expected_pixels.size();
    end

endmodule

[tb/tb_textured_column_renderer.sv]
// Testbench top for the textured column renderer: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_textured_column_renderer;
    import tcr_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_IGNORED = 2'd3;

    localparam int IDLE_PCT       = 22;
    localparam int QUIET_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int DRAIN_CYCLES   = 50;
    localparam int HOLD_CYCLES    = 200;
    localparam int PRESSURE_TICKS = 220;
    localparam int TOTAL_ITEMS    = 650;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [FUNC_W-1:0]    s_tuser     = FUNC_ROW;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_CEILING;
    logic [COLOR_W-1:0]   cfg_wr_data = '0;

    int   fail_count;
    int   pending_pixels;
    int   quiet_cycles = 0;
    int   hold_left    = 0;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;
    logic idle_on      = 1'b1;

    int   cur_height = RST_SCREEN_HEIGHT;
    int   items_sent = 0;
    int   loaded_sel[$];
    int   loaded_col[$];

    always #5 aclk = ~aclk;

    textured_column_renderer DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    tcr_pixel_checker pixel_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .fail_count     (fail_count),
        .pending_pixels (pending_pixels)
    );

    // Receiver: random back-pressure, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: count cycles without any transfer or register write
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_textured_column_renderer: FAIL");
            $finish;
        end
    end

    function automatic logic [S_TDATA_W-1:0] rand_bits();
        return {$urandom(), $urandom(), $urandom()};
    endfunction

    function automatic logic [S_TDATA_W-1:0] column_item(
        input logic [COORD_W-1:0]  col,
        input logic [COORD_W-1:0]  first_row,
        input logic [COORD_W-1:0]  end_row,
        input logic [HEIGHT_W-1:0] wall,
        input logic [TEXCOL_W-1:0] tcol,
        input logic [SEL_W-1:0]    tsel
    );
        logic [S_TDATA_W-1:0] r;
        r = rand_bits();
        return {r[95:60], tsel, tcol, wall, end_row, first_row, col};
    endfunction

    function automatic logic [S_TDATA_W-1:0] texel_item(
        input logic [SEL_W-1:0]    tsel,
        input logic [TEXIDX_W-1:0] idx,
        input logic [COLOR_W-1:0]  rgb
    );
        logic [S_TDATA_W-1:0] r;
        r = rand_bits();
        return {rgb, idx, tsel, r[57:0]};
    endfunction

    // Offer one item and hold it until the transfer; returns at a falling edge
    task automatic send(input logic [FUNC_W-1:0] f, input logic [S_TDATA_W-1:0] d);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (f != FUNC_IGNORED) items_sent++;
    endtask

    task automatic tick();
        send(FUNC_ROW, rand_bits());
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_pixels != 0) @(negedge aclk);
        // a column start may still be dividing
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_registers(
        input logic [COLOR_W-1:0] ceil_rgb,
        input logic [COLOR_W-1:0] flr_rgb,
        input logic [COORD_W-1:0] width,
        input logic [COORD_W-1:0] height
    );
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_CEILING;
        cfg_wr_data <= ceil_rgb;
        @(negedge aclk);
        cfg_index   <= CFG_FLOOR;
        cfg_wr_data <= flr_rgb;
        @(negedge aclk);
        cfg_index   <= CFG_WIDTH;
        cfg_wr_data <= {12'd0, width};
        @(negedge aclk);
        cfg_index   <= CFG_HEIGHT;
        cfg_wr_data <= {12'd0, height};
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_height = height;
    endtask

    // Fill every row of one texture column so any position read along it is defined
    task automatic load_tex_column(input int tsel, input int tcol);
        for (int r = 0; r < 64; r++) begin
            send(FUNC_TEXEL, texel_item(SEL_W'(tsel), {6'(r), 6'(tcol)}, COLOR_W'($urandom())));
        end
        loaded_sel.push_back(tsel);
        loaded_col.push_back(tcol);
    endtask

    task automatic noise();
        if ($urandom_range(0, 1) == 0) begin
            send(FUNC_IGNORED, rand_bits());
        end else begin
            send(FUNC_TEXEL, texel_item(SEL_W'($urandom_range(0, 3)),
                                        TEXIDX_W'($urandom_range(0, 4095)),
                                        COLOR_W'($urandom())));
        end
    endtask

    // Start a column on a loaded texture column and tick through it; nticks < 0 picks a count
    task automatic draw_column(input int nticks);
        int pick, span_top, first_row, end_row, wall, col;
        pick     = $urandom_range(0, loaded_sel.size() - 1);
        span_top = (cur_height > 300) ? 300 : cur_height;
        first_row = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(0, span_top);
        end_row   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(0, span_top + 2);
        case ($urandom_range(0, 9))
            0:       wall = 0;
            1:       wall = 65535;
            2, 3:    wall = $urandom_range(1, 65535);
            default: wall = $urandom_range(1, 2 * span_top + 2);
        endcase
        col = $urandom_range(0, 4095);
        send(FUNC_COLUMN, column_item(COORD_W'(col), COORD_W'(first_row), COORD_W'(end_row),
                                      HEIGHT_W'(wall), TEXCOL_W'(loaded_col[pick]),
                                      SEL_W'(loaded_sel[pick])));
        if (nticks < 0) begin
            if (cur_height > 300)
                nticks = $urandom_range(20, 150);
            else if ($urandom_range(0, 3) == 0)
                nticks = $urandom_range(0, cur_height);
            else
                nticks = cur_height + $urandom_range(0, 2);
        end
        repeat (nticks) begin
            if ($urandom_range(0, 99) < 8) noise();
            tick();
        end
    endtask

    initial begin
        int phase;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ticks before any column start draw nothing
        tick();
        send(FUNC_IGNORED, rand_bits());
        tick();

        load_tex_column(0, 0);
        load_tex_column(3, 63);
        load_tex_column(1, 21);
        load_tex_column(2, 42);

        set_registers(24'hFFFFFF, 24'h000000, 12'd4095, 12'd4);
        // span inside the rows, tallest wall, one extra tick past the last row
        send(FUNC_COLUMN, column_item(12'd4095, 12'd1, 12'd3, 16'd65535, 6'd63, 2'd3));
        repeat (5) tick();
        // zero wall height, span to the bottom of the field range
        send(FUNC_COLUMN, column_item(12'd0, 12'd0, 12'd4095, 16'd0, 6'd0, 2'd0));
        repeat (4) tick();
        // span end before span start: no texel rows
        send(FUNC_COLUMN, column_item(12'd2730, 12'd3, 12'd1, 16'd1, 6'd21, 2'd1));
        repeat (4) tick();
        send(FUNC_IGNORED, rand_bits());
        // lower the height below the current row mid-column
        send(FUNC_COLUMN, column_item(12'd7, 12'd0, 12'd4, 16'd4, 6'd42, 2'd2));
        repeat (2) tick();
        set_registers(24'h000000, 24'hFFFFFF, 12'd1, 12'd1);
        repeat (2) tick();

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            idle_on <= !(phase == 1 || phase == 2);
            case (phase)
                0: set_registers(24'hFFFFFF, 24'h000000, 12'd4095, 12'd4095);
                1: set_registers(24'h000000, 24'hFFFFFF, 12'd1, 12'd1);
                default: set_registers(COLOR_W'($urandom()), COLOR_W'($urandom()),
                                       COORD_W'($urandom_range(1, 4095)),
                                       ($urandom_range(0, 3) == 0) ?
                                           COORD_W'($urandom_range(41, 200)) :
                                           COORD_W'($urandom_range(1, 40)));
            endcase
            if (phase == 0) begin
                // stall the receiver while a long column keeps streaming
                hold_req <= 1'b1;
                draw_column(PRESSURE_TICKS);
            end else begin
                repeat ($urandom_range(3, 6)) draw_column(-1);
            end
            if (phase % 3 == 2) load_tex_column($urandom_range(0, 3), $urandom_range(0, 63));
            phase++;
        end

        s_tvalid <= 1'b0;
        while (pending_pixels != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending_pixels == 0) begin
            $display("tb_textured_column_renderer: PASS");
        end else begin
            $display("tb_textured_column_renderer: FAIL");
        end
        $finish;
    end

endmodule
